@@ rtl/psd_pkg.sv @@
// Shared widths, vector types and region codes of the point to segment distance unit.
package psd_pkg;

	// Difference of two 32-bit coordinates
	localparam int COORD_W = 33;
	// Product of two differences
	localparam int PROD_W = 2 * COORD_W;
	// Sum of three products, dot products
	localparam int DOT_W = PROD_W + 2;
	// Long division remainder (below twice the divisor)
	localparam int DREM_W = DOT_W + 1;
	// Final residual component, signed
	localparam int RES_W = COORD_W + 2;
	// Magnitude of a residual component
	localparam int MAG_W = RES_W - 1;
	// Sum of three squares
	localparam int SQS_W = 2 * MAG_W + 2;
	// Square root bits, one per stage
	localparam int ROOT_W = SQS_W / 2;
	// Square root remainder
	localparam int SREM_W = ROOT_W + 2;
	// Distance output
	localparam int DIST_W = 33;
	localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

	// Region codes
	localparam logic [1:0] REGION_START    = 2'd0;
	localparam logic [1:0] REGION_END      = 2'd1;
	localparam logic [1:0] REGION_INTERIOR = 2'd2;
	localparam logic [1:0] REGION_NONE     = 2'd3;

	// Three coordinate differences
	typedef logic [2:0][COORD_W-1:0] vec3_t;

endpackage

@@ rtl/point_segment_distance_unit.sv @@
// Pipelined point to 3-D segment distance unit, one query per cycle.
//
// Command channel: a query word (point, segment start, segment end, signed
// fixed point with FRAC_BITS fraction bits) is taken at every rising edge
// with start high and busy low. busy is never raised: the pipeline takes a
// new word in every cycle.
// Result channel: done is high for exactly one cycle with dist_res (unsigned,
// FRAC_BITS fraction bits, saturating) and region (0 start or zero-length
// segment, 1 end, 2 interior). The receiver has no way to hold results off.
// Throughput is one word per cycle.
// The depth is set by the restoring divider for the projection factor
// (FRAC_BITS + 1 stages, one quotient bit each) and by the square root
// (35 stages, one root bit each), plus eight stages of differences,
// products, sums and region choice, and the output register.
// Reset: arst_n clears every valid bit at once; words in flight are dropped.
// Results appear in the order the queries were accepted.
module point_segment_distance_unit #(
	parameter int FRAC_BITS = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  logic signed [31:0]      point_x,
	input  logic signed [31:0]      point_y,
	input  logic signed [31:0]      point_z,
	input  logic signed [31:0]      start_x,
	input  logic signed [31:0]      start_y,
	input  logic signed [31:0]      start_z,
	input  logic signed [31:0]      end_x,
	input  logic signed [31:0]      end_y,
	input  logic signed [31:0]      end_z,
	output logic                    done,
	output logic [psd_pkg::DIST_W-1:0] dist_res,
	output logic [1:0]              region
);
	import psd_pkg::*;

	localparam int DIV_N = FRAC_BITS + 1;
	localparam int PT_W = COORD_W + FRAC_BITS + 2;
	localparam logic signed [PT_W-1:0] HALF = PT_W'(1) <<< (FRAC_BITS - 1);

	assign busy = 1'b0;

	// Stage 1: differences
	logic signed [31:0] p_in [3];
	logic signed [31:0] s_in [3];
	logic signed [31:0] e_in [3];
	logic               vld_s1;
	vec3_t              n_s1, v_s1, pe_s1;

	assign p_in[0] = point_x;
	assign p_in[1] = point_y;
	assign p_in[2] = point_z;
	assign s_in[0] = start_x;
	assign s_in[1] = start_y;
	assign s_in[2] = start_z;
	assign e_in[0] = end_x;
	assign e_in[1] = end_y;
	assign e_in[2] = end_z;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			n_s1[i]  <= COORD_W'(e_in[i]) - COORD_W'(s_in[i]);
			v_s1[i]  <= COORD_W'(p_in[i]) - COORD_W'(s_in[i]);
			pe_s1[i] <= COORD_W'(p_in[i]) - COORD_W'(e_in[i]);
		end
	end

	// Stage 2: products for n.v and n.n
	logic                     vld_s2;
	logic signed [PROD_W-1:0] nv_s2 [3];
	logic signed [PROD_W-1:0] nn_s2 [3];
	vec3_t                    n_s2, v_s2, pe_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			nv_s2[i] <= $signed(n_s1[i]) * $signed(v_s1[i]);
			nn_s2[i] <= $signed(n_s1[i]) * $signed(n_s1[i]);
		end
		n_s2  <= n_s1;
		v_s2  <= v_s1;
		pe_s2 <= pe_s1;
	end

	// Stage 3: dot product sums
	logic                    vld_s3;
	logic signed [DOT_W-1:0] c_s3;
	logic [DOT_W-1:0]        nn_s3;
	vec3_t                   n_s3, v_s3, pe_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		c_s3  <= DOT_W'(nv_s2[0]) + DOT_W'(nv_s2[1]) + DOT_W'(nv_s2[2]);
		nn_s3 <= DOT_W'(nn_s2[0]) + DOT_W'(nn_s2[1]) + DOT_W'(nn_s2[2]);
		n_s3  <= n_s2;
		v_s3  <= v_s2;
		pe_s3 <= pe_s2;
	end

	// Stage 4: region choice; only interior words load c as the dividend, others load zero
	logic              vld_s4;
	logic [1:0]        reg_s4;
	logic [DREM_W-1:0] rem_s4;
	logic [DOT_W-1:0]  nn_s4;
	vec3_t             n_s4, a_s4;
	logic              at_start, past_end;

	assign at_start = (nn_s3 == '0) || c_s3[DOT_W-1];
	assign past_end = nn_s3 < $unsigned(c_s3);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else begin
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		nn_s4 <= nn_s3;
		n_s4  <= n_s3;
		if (at_start) begin
			reg_s4 <= REGION_START;
			rem_s4 <= '0;
			a_s4   <= v_s3;
		end else if (past_end) begin
			reg_s4 <= REGION_END;
			rem_s4 <= '0;
			a_s4   <= pe_s3;
		end else begin
			reg_s4 <= REGION_INTERIOR;
			rem_s4 <= DREM_W'($unsigned(c_s3));
			a_s4   <= v_s3;
		end
	end

	// Divider: t = floor(c * 2^F / nn), one quotient bit per stage
	logic                 dv_vld_s [DIV_N+1];
	logic [1:0]           dv_reg_s [DIV_N+1];
	logic [DREM_W-1:0]    dv_rem_s [DIV_N+1];
	logic [DOT_W-1:0]     dv_nn_s  [DIV_N+1];
	logic [FRAC_BITS:0]   dv_q_s   [DIV_N+1];
	vec3_t                dv_n_s   [DIV_N+1];
	vec3_t                dv_a_s   [DIV_N+1];

	assign dv_vld_s[0] = vld_s4;
	assign dv_reg_s[0] = reg_s4;
	assign dv_rem_s[0] = rem_s4;
	assign dv_nn_s[0]  = nn_s4;
	assign dv_q_s[0]   = '0;
	assign dv_n_s[0]   = n_s4;
	assign dv_a_s[0]   = a_s4;

	for (genvar j = 0; j < DIV_N; j++) begin : g_div
		logic              ge;
		logic [DREM_W-1:0] diff;

		assign ge   = dv_rem_s[j] >= {1'b0, dv_nn_s[j]};
		assign diff = ge ? dv_rem_s[j] - {1'b0, dv_nn_s[j]} : dv_rem_s[j];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_vld_s[j+1] <= 1'b0;
			end else begin
				dv_vld_s[j+1] <= dv_vld_s[j];
			end
		end

		always_ff @(posedge clk) begin
			dv_reg_s[j+1] <= dv_reg_s[j];
			dv_rem_s[j+1] <= {diff[DREM_W-2:0], 1'b0};
			dv_nn_s[j+1]  <= dv_nn_s[j];
			dv_q_s[j+1]   <= {dv_q_s[j][FRAC_BITS-1:0], ge};
			dv_n_s[j+1]   <= dv_n_s[j];
			dv_a_s[j+1]   <= dv_a_s[j];
		end
	end

	// Stage T: n * t per axis
	logic                   vld_st;
	logic [1:0]             reg_st;
	logic signed [PT_W-1:0] nt_st [3];
	vec3_t                  a_st;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_st <= 1'b0;
		end else begin
			vld_st <= dv_vld_s[DIV_N];
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			nt_st[i] <= PT_W'($signed(dv_n_s[DIV_N][i]) * $signed({1'b0, dv_q_s[DIV_N]}));
		end
		reg_st <= dv_reg_s[DIV_N];
		a_st   <= dv_a_s[DIV_N];
	end

	// Stage W: residual a - round(n * t); t is zero outside the interior
	logic                    vld_sw;
	logic [1:0]              reg_sw;
	logic signed [RES_W-1:0] w_sw [3];
	logic signed [PT_W-1:0]  rnd [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			rnd[i] = (nt_st[i] + HALF) >>> FRAC_BITS;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_sw <= 1'b0;
		end else begin
			vld_sw <= vld_st;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			w_sw[i] <= RES_W'($signed(a_st[i])) - RES_W'(rnd[i]);
		end
		reg_sw <= reg_st;
	end

	// Stage Q: squares of the magnitudes
	logic                 vld_sq;
	logic [1:0]           reg_sq;
	logic [2*MAG_W-1:0]   sq_sq [3];
	logic [MAG_W-1:0]     mag [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			mag[i] = w_sw[i][RES_W-1] ? MAG_W'(-w_sw[i]) : MAG_W'(w_sw[i]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_sq <= 1'b0;
		end else begin
			vld_sq <= vld_sw;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			sq_sq[i] <= mag[i] * mag[i];
		end
		reg_sq <= reg_sw;
	end

	// Stage S: sum of squares
	logic              vld_ss;
	logic [1:0]        reg_ss;
	logic [SQS_W-1:0]  sum_ss;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_ss <= 1'b0;
		end else begin
			vld_ss <= vld_sq;
		end
	end

	always_ff @(posedge clk) begin
		sum_ss <= SQS_W'(sq_sq[0]) + SQS_W'(sq_sq[1]) + SQS_W'(sq_sq[2]);
		reg_ss <= reg_sq;
	end

	// Square root: one root bit per stage, two radicand bits consumed each
	logic              rt_vld_s  [ROOT_W+1];
	logic [1:0]        rt_reg_s  [ROOT_W+1];
	logic [SQS_W-1:0]  rt_x_s    [ROOT_W+1];
	logic [SREM_W-1:0] rt_rem_s  [ROOT_W+1];
	logic [ROOT_W-1:0] rt_root_s [ROOT_W+1];

	assign rt_vld_s[0]  = vld_ss;
	assign rt_reg_s[0]  = reg_ss;
	assign rt_x_s[0]    = sum_ss;
	assign rt_rem_s[0]  = '0;
	assign rt_root_s[0] = '0;

	for (genvar j = 0; j < ROOT_W; j++) begin : g_sqrt
		logic [SREM_W+1:0] shifted;
		logic [SREM_W+1:0] trial;
		logic              ge;

		assign shifted = {rt_rem_s[j], rt_x_s[j][SQS_W-1 -: 2]};
		assign trial   = (SREM_W+2)'({rt_root_s[j], 2'b01});
		assign ge      = shifted >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				rt_vld_s[j+1] <= 1'b0;
			end else begin
				rt_vld_s[j+1] <= rt_vld_s[j];
			end
		end

		always_ff @(posedge clk) begin
			rt_reg_s[j+1]  <= rt_reg_s[j];
			rt_x_s[j+1]    <= {rt_x_s[j][SQS_W-3:0], 2'b00};
			rt_rem_s[j+1]  <= ge ? SREM_W'(shifted - trial) : SREM_W'(shifted);
			rt_root_s[j+1] <= {rt_root_s[j][ROOT_W-2:0], ge};
		end
	end

	// Output register with saturation
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= rt_vld_s[ROOT_W];
		end
	end

	always_ff @(posedge clk) begin
		region   <= rt_reg_s[ROOT_W];
		dist_res <= (rt_root_s[ROOT_W] > ROOT_W'(DIST_MAX)) ? DIST_MAX
			: rt_root_s[ROOT_W][DIST_W-1:0];
	end

endmodule

@@ rtl/psd_checker.sv @@
// Port-level checker for the point to segment distance unit, with its bind.
module psd_checker #(
	parameter int FRAC_BITS = 16
) (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         start,
	input logic                         busy,
	input logic                         done,
	input logic [psd_pkg::DIST_W-1:0]   dist_res,
	input logic [1:0]                   region
);
	import psd_pkg::*;

	localparam int LATENCY = FRAC_BITS + 45;

	// The pipeline never refuses a word
	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("busy raised");

	// Every result comes from a word accepted a fixed time earlier
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LATENCY))
		else $error("result without matching query");

	// Region code three is never reported
	a_region: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (region != REGION_NONE))
		else $error("bad region code");

	// A result word carries known bits
	a_known: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !$isunknown({dist_res, region}))
		else $error("unknown result bits");

endmodule

bind point_segment_distance_unit psd_checker #(.FRAC_BITS(FRAC_BITS)) u_psd_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.start    (start),
	.busy     (busy),
	.done     (done),
	.dist_res (dist_res),
	.region   (region)
);
